// File: design/zcdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcdp_pkg: shared types and constants
// Result record, result codes and stream constants of the central directory
// parser.
// ----------------------------------------------------------------------------
package zcdp_pkg;

   // result codes
   localparam logic [1:0] KIND_NAME_BYTE = 2'd0;
   localparam logic [1:0] KIND_ENTRY     = 2'd1;
   localparam logic [1:0] KIND_STOPPED   = 2'd2;

   localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;
   localparam logic [63:0] ALL_ONES32   = 64'h0000_0000_ffff_ffff;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  name_byte;
      logic [63:0] header_offset;
      logic [63:0] compressed_size;
      logic [15:0] name_length;
      logic        last_result;
   } zcdp_result_type;

   // up to two results caused by one input beat
   typedef struct packed {
      logic [1:0]      count;
      zcdp_result_type first;
      zcdp_result_type second;
   } zcdp_push_type;

endpackage
`default_nettype wire

// File: design/zcdp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcdp_core: parser state and per-byte update
// Consumes one stream byte per accepted beat and reports the results it causes.
// ----------------------------------------------------------------------------
module zcdp_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   beat_accept,
   input  wire logic [7:0]             data_byte,
   output zcdp_pkg::zcdp_push_type     push
);
   import zcdp_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT, PH_HEADER, PH_NAME, PH_SUBHDR, PH_BODY, PH_COMMENT, PH_CHECK, PH_STOPPED
   } phase_type;

   localparam logic [15:0] HEADER_BYTES = 16'd46;
   localparam logic [1:0]  SLOT_NONE    = 2'd3;

   phase_type   phase_ff, phase_in;
   logic [31:0] window_ff, window_in;
   logic [15:0] bpos_ff, bpos_in;
   logic [63:0] csize_ff, csize_in;
   logic [63:0] usize_ff, usize_in;
   logic [63:0] offset_ff, offset_in;
   logic [15:0] name_len_ff, name_len_in;
   logic [15:0] extra_len_ff, extra_len_in;
   logic [15:0] comment_len_ff, comment_len_in;
   logic [15:0] extra_rem_ff, extra_rem_in;
   logic [15:0] sub_id_ff, sub_id_in;
   logic [15:0] sub_rem_ff, sub_rem_in;
   logic [63:0] wide_ff, wide_in;
   logic [1:0]  slot_ff, slot_in;

   // first slot at or after s whose 32-bit value is all ones
   function automatic logic [1:0] next_slot(input logic [1:0] s, input logic [63:0] u,
                                            input logic [63:0] c, input logic [63:0] o);
      logic [1:0] r;
      r = SLOT_NONE;
      if (s == 2'd0 && u == ALL_ONES32)
         r = 2'd0;
      else if (s <= 2'd1 && c == ALL_ONES32)
         r = 2'd1;
      else if (s <= 2'd2 && o == ALL_ONES32)
         r = 2'd2;
      return r;
   endfunction

   always_comb begin
      logic            go_name, go_extra, go_sub, finish, go_comment, go_check;
      logic [1:0]      n;
      zcdp_result_type rec;
      logic [15:0]     p;

      phase_in       = phase_ff;
      window_in      = window_ff;
      bpos_in        = bpos_ff;
      csize_in       = csize_ff;
      usize_in       = usize_ff;
      offset_in      = offset_ff;
      name_len_in    = name_len_ff;
      extra_len_in   = extra_len_ff;
      comment_len_in = comment_len_ff;
      extra_rem_in   = extra_rem_ff;
      sub_id_in      = sub_id_ff;
      sub_rem_in     = sub_rem_ff;
      wide_in        = wide_ff;
      slot_in        = slot_ff;
      go_name    = 1'b0;
      go_extra   = 1'b0;
      go_sub     = 1'b0;
      finish     = 1'b0;
      go_comment = 1'b0;
      go_check   = 1'b0;
      n          = 2'd0;
      rec        = '0;
      p          = bpos_ff;
      push       = '0;

      if (beat_accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               window_in = {data_byte, window_ff[31:8]};
               if (window_in == CD_SIGNATURE) begin
                  phase_in       = PH_HEADER;
                  bpos_in        = 16'd4;
                  csize_in       = '0;
                  usize_in       = '0;
                  offset_in      = '0;
                  name_len_in    = '0;
                  extra_len_in   = '0;
                  comment_len_in = '0;
               end
            end
            PH_HEADER: begin
               if (p >= 16'd20 && p < 16'd24)
                  csize_in[{p[1:0], 3'b000} +: 8] = csize_ff[{p[1:0], 3'b000} +: 8] | data_byte;
               else if (p >= 16'd24 && p < 16'd28)
                  usize_in[{p[1:0], 3'b000} +: 8] = usize_ff[{p[1:0], 3'b000} +: 8] | data_byte;
               else if (p >= 16'd28 && p < 16'd30)
                  name_len_in[{p[0], 3'b000} +: 8] =
                     name_len_ff[{p[0], 3'b000} +: 8] | data_byte;
               else if (p >= 16'd30 && p < 16'd32)
                  extra_len_in[{p[0], 3'b000} +: 8] =
                     extra_len_ff[{p[0], 3'b000} +: 8] | data_byte;
               else if (p >= 16'd32 && p < 16'd34)
                  comment_len_in[{p[0], 3'b000} +: 8] =
                     comment_len_ff[{p[0], 3'b000} +: 8] | data_byte;
               else if (p >= 16'd42 && p < 16'd46)
                  offset_in[{p[1:0] + 2'd2, 3'b000} +: 8] =
                     offset_ff[{p[1:0] + 2'd2, 3'b000} +: 8] | data_byte;
               bpos_in = bpos_ff + 16'd1;
               if (bpos_in >= HEADER_BYTES)
                  go_name = 1'b1;
            end
            PH_NAME: begin
               rec             = '0;
               rec.result_kind = KIND_NAME_BYTE;
               rec.name_byte   = data_byte;
               push.first      = rec;
               n               = 2'd1;
               bpos_in         = bpos_ff + 16'd1;
               if (bpos_in >= name_len_ff)
                  go_extra = 1'b1;
            end
            PH_SUBHDR: begin
               extra_rem_in = extra_rem_ff - 16'd1;
               if (p < 16'd2)
                  sub_id_in[{p[0], 3'b000} +: 8] = sub_id_ff[{p[0], 3'b000} +: 8] | data_byte;
               else
                  sub_rem_in[{p[0], 3'b000} +: 8] = sub_rem_ff[{p[0], 3'b000} +: 8] | data_byte;
               bpos_in = bpos_ff + 16'd1;
               if (bpos_in >= 16'd4) begin
                  if (sub_rem_in > extra_rem_in)
                     sub_rem_in = extra_rem_in;
                  slot_in = (sub_id_in == 16'd1) ?
                            next_slot(2'd0, usize_ff, csize_ff, offset_ff) : SLOT_NONE;
                  bpos_in = '0;
                  wide_in = '0;
                  if (sub_rem_in == 16'd0)
                     go_sub = 1'b1;
                  else
                     phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               extra_rem_in = extra_rem_ff - 16'd1;
               sub_rem_in   = sub_rem_ff - 16'd1;
               if (slot_ff != SLOT_NONE) begin
                  wide_in[{p[2:0], 3'b000} +: 8] = wide_ff[{p[2:0], 3'b000} +: 8] | data_byte;
                  bpos_in = bpos_ff + 16'd1;
                  if (bpos_in >= 16'd8) begin
                     case (slot_ff)
                        2'd0:    usize_in  = wide_in;
                        2'd1:    csize_in  = wide_in;
                        default: offset_in = wide_in;
                     endcase
                     slot_in = next_slot(slot_ff + 2'd1, usize_in, csize_in, offset_in);
                     bpos_in = '0;
                     wide_in = '0;
                  end
               end
               if (sub_rem_in == 16'd0)
                  go_sub = 1'b1;
            end
            PH_COMMENT: begin
               comment_len_in = comment_len_ff - 16'd1;
               if (comment_len_in == 16'd0)
                  go_check = 1'b1;
            end
            PH_CHECK: begin
               window_in = {data_byte, window_ff[31:8]};
               bpos_in   = bpos_ff + 16'd1;
               if (bpos_in >= 16'd4) begin
                  if (window_in == CD_SIGNATURE) begin
                     phase_in       = PH_HEADER;
                     bpos_in        = 16'd4;
                     csize_in       = '0;
                     usize_in       = '0;
                     offset_in      = '0;
                     name_len_in    = '0;
                     extra_len_in   = '0;
                     comment_len_in = '0;
                  end else begin
                     rec             = '0;
                     rec.result_kind = KIND_STOPPED;
                     push.first      = rec;
                     n               = 2'd1;
                     phase_in        = PH_STOPPED;
                  end
               end
            end
            PH_STOPPED: begin
            end
            default: begin
            end
         endcase

         // phase transitions that fall through empty sections
         if (go_name) begin
            if (name_len_in == 16'd0) begin
               go_extra = 1'b1;
            end else begin
               phase_in = PH_NAME;
               bpos_in  = '0;
            end
         end
         if (go_extra) begin
            extra_rem_in = extra_len_in;
            go_sub       = 1'b1;
         end
         if (go_sub) begin
            if (extra_rem_in == 16'd0) begin
               finish = 1'b1;
            end else if (extra_rem_in < 16'd4) begin
               // short tail: skipped unread
               sub_id_in  = '0;
               sub_rem_in = extra_rem_in;
               slot_in    = SLOT_NONE;
               bpos_in    = '0;
               wide_in    = '0;
               phase_in   = PH_BODY;
            end else begin
               phase_in   = PH_SUBHDR;
               bpos_in    = '0;
               sub_id_in  = '0;
               sub_rem_in = '0;
            end
         end
         if (finish) begin
            rec                 = '0;
            rec.result_kind     = KIND_ENTRY;
            rec.header_offset   = offset_in;
            rec.compressed_size = csize_in;
            rec.name_length     = name_len_in;
            if (n == 2'd0)
               push.first = rec;
            else
               push.second = rec;
            n          = n + 2'd1;
            go_comment = 1'b1;
         end
         if (go_comment) begin
            if (comment_len_in == 16'd0)
               go_check = 1'b1;
            else
               phase_in = PH_COMMENT;
         end
         if (go_check) begin
            phase_in  = PH_CHECK;
            bpos_in   = '0;
            window_in = '0;
         end

         if (n == 2'd1)
            push.first.last_result = 1'b1;
         else if (n == 2'd2)
            push.second.last_result = 1'b1;
      end
      push.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         window_ff      <= '0;
         bpos_ff        <= '0;
         csize_ff       <= '0;
         usize_ff       <= '0;
         offset_ff      <= '0;
         name_len_ff    <= '0;
         extra_len_ff   <= '0;
         comment_len_ff <= '0;
         extra_rem_ff   <= '0;
         sub_id_ff      <= '0;
         sub_rem_ff     <= '0;
         wide_ff        <= '0;
         slot_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         window_ff      <= window_in;
         bpos_ff        <= bpos_in;
         csize_ff       <= csize_in;
         usize_ff       <= usize_in;
         offset_ff      <= offset_in;
         name_len_ff    <= name_len_in;
         extra_len_ff   <= extra_len_in;
         comment_len_ff <= comment_len_in;
         extra_rem_ff   <= extra_rem_in;
         sub_id_ff      <= sub_id_in;
         sub_rem_ff     <= sub_rem_in;
         wide_ff        <= wide_in;
         slot_ff        <= slot_in;
      end
   end

endmodule
`default_nettype wire

// File: design/zcdp_rsp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcdp_rsp_fifo: result queue
// Takes up to two results per cycle, hands out one per rsp beat.
// ----------------------------------------------------------------------------
module zcdp_rsp_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire zcdp_pkg::zcdp_push_type   push,
   output logic                           room_for_two,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output zcdp_pkg::zcdp_result_type      out_data
);
   import zcdp_pkg::*;

   zcdp_result_type        entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign out_valid    = (count_ff != '0);
   assign out_data     = entry_ff[rd_ptr_ff];
   assign pop          = out_valid & out_ready;
   assign room_for_two = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0)
         entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2)
         entry_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
   end

endmodule
`default_nettype wire

// File: design/zip_central_directory_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zip_central_directory_parser_unit: ZIP central directory walker
// Hunts the stream for the first header, streams out name bytes, applies zip64
// size/offset overrides, reports one record per entry, stops if no header follows.
// ----------------------------------------------------------------------------
// Results: the results of a req beat are written into the result queue and
//   reach rsp from there; a second result of the same beat follows the first.
// Throughput: one req beat per cycle; a byte causes at most two results, held
//   in a four-deep result queue, so req_ready drops only while the queue has
//   fewer than two free places (rsp side stalled or draining a double result).
// Reset: synchronous, active high; parser returns to hunting, queue empties.
// ----------------------------------------------------------------------------
module zip_central_directory_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_name_byte,
   output logic [63:0]      rsp_header_offset,
   output logic [63:0]      rsp_compressed_size,
   output logic [15:0]      rsp_name_length,
   output logic             rsp_last_result
);
   import zcdp_pkg::*;

   zcdp_push_type   push;
   zcdp_result_type head;
   logic            room_for_two;
   logic            beat_accept;

   // a byte is only taken when the queue can hold the worst case of two results
   assign req_ready   = room_for_two;
   assign beat_accept = req_valid & req_ready;

   // per-byte parser: state registers plus the short update logic
   zcdp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .data_byte   (req_data_byte),
      .push        (push)
   );

   // result queue decouples the rsp handshake from the byte stream
   zcdp_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_data     (head)
   );

   assign rsp_result_kind     = head.result_kind;
   assign rsp_name_byte       = head.name_byte;
   assign rsp_header_offset   = head.header_offset;
   assign rsp_compressed_size = head.compressed_size;
   assign rsp_name_length     = head.name_length;
   assign rsp_last_result     = head.last_result;

endmodule
`default_nettype wire
